### hdl/fpr_pkg.sv
// Shared types and constants for the FIFO page replacement block.
// No dependencies; the top level imports it.
package fpr_pkg;

    localparam int unsigned PB_W    = 17;  // page size register width
    localparam int unsigned FC_W    = 7;   // frame count register width
    localparam int unsigned TAG_W   = 32;  // virtual page number width
    localparam int unsigned PA_W    = 22;  // physical address width
    localparam int unsigned OFF_W   = 32;  // virtual offset width on the port
    localparam int unsigned KIND_W  = 2;
    localparam int unsigned OUT_W   = 88;  // result tdata width, byte aligned

    localparam logic [PB_W-1:0] PB_RESET = 17'd4096;
    localparam logic [PB_W-1:0] PB_MAX   = 17'd65536;
    localparam logic [PB_W-1:0] PB_MIN   = 17'd1;
    localparam logic [FC_W-1:0] FC_RESET = 7'd64;

    // register index, taken from paddr[2]
    localparam logic REG_PAGE_BYTES = 1'b0;
    localparam logic REG_FRAMES     = 1'b1;

    localparam logic [KIND_W-1:0] KIND_HIT = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_SRCH,
        ST_VRD,
        ST_VCAP,
        ST_MUL,
        ST_ADD,
        ST_OUT
    } t_state;

endpackage

### hdl/fifo_page_replacement.sv
// FIFO page replacement engine: divider, tag memory walk and result register.
// Depends on fpr_pkg.

// Usage
// Slave channel: one page fault per beat. i_s_tdata carries the byte offset into
// the virtual region, i_s_tuser the write flag. Master channel: one result beat
// per fault with page number, eviction info and physical address in o_m_tdata
// and the fault kind in o_m_tuser (0 read miss, 1 write miss, 2 hit).
// APB port: page size at 0x0, frame count at 0x4; write only while idle.
// Per fault: accept, restoring division of the offset by the page size (one
// quotient bit a cycle), a tag walk through the frame memory (one read a
// cycle, first match wins), on an eviction a read of the victim entry, then
// multiply, add/write back and output.
// One fault is in flight at a time; the next is taken as soon as the engine
// is idle, even while the previous result still waits in the output register.
// If the receiver stalls, the finished result holds in the engine until the
// output register frees up. Reset clears the fill count, the eviction
// pointer and the config registers to their defaults; frame memory contents
// are not cleared; only entries below the fill count are ever used.
module fifo_page_replacement #(
    parameter int unsigned MAX_FRAMES = 64,
    parameter int unsigned ADDR_BITS  = 32
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_s_tvalid,
    output logic                       o_s_tready,
    input  logic [fpr_pkg::OFF_W-1:0]  i_s_tdata,   // [31:0] virtual_offset
    input  logic [0:0]                 i_s_tuser,   // [0] is_write
    output logic                       o_m_tvalid,
    input  logic                       i_m_tready,
    // [31:0] vpn, [32] evicted_valid, [64:33] victim_vpn,
    // [65] write_back, [87:66] phys_addr
    output logic [fpr_pkg::OUT_W-1:0]  o_m_tdata,
    output logic [fpr_pkg::KIND_W-1:0] o_m_tuser,   // [1:0] fault_kind
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [2:0]                 paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready
);
    import fpr_pkg::*;

    localparam int unsigned VA_W = (ADDR_BITS < OFF_W) ? ADDR_BITS : OFF_W;
    localparam int unsigned DC_W = $clog2(VA_W + 1);
    localparam int unsigned FW   = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
    localparam int unsigned CW   = $clog2(MAX_FRAMES + 1);
    localparam int unsigned MW   = TAG_W + 1;
    localparam int unsigned PW   = FW + PB_W;

    // configuration
    logic [PB_W-1:0] r_page_bytes;
    logic [FC_W-1:0] r_frames;
    logic            cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_page_bytes <= PB_RESET;
            r_frames     <= FC_RESET;
        end else if (cfg_wr) begin
            if (paddr[2] == REG_FRAMES) begin
                r_frames <= pwdata[FC_W-1:0];
            end else begin
                r_page_bytes <= pwdata[PB_W-1:0];
            end
        end
    end

    always_comb begin
        if (paddr[2] == REG_FRAMES) begin
            prdata = {{(32-FC_W){1'b0}}, r_frames};
        end else begin
            prdata = {{(32-PB_W){1'b0}}, r_page_bytes};
        end
    end

    logic [PB_W-1:0] psz;
    logic [CW-1:0]   limit;

    always_comb begin
        if (r_page_bytes == '0) begin
            psz = PB_MIN;
        end else if (r_page_bytes > PB_MAX) begin
            psz = PB_MAX;
        end else begin
            psz = r_page_bytes;
        end
        if (r_frames == '0) begin
            limit = CW'(1);
        end else if (32'(r_frames) > MAX_FRAMES) begin
            limit = CW'(MAX_FRAMES);
        end else begin
            limit = CW'(r_frames);
        end
    end

    // engine state
    t_state r_state, n_state;

    logic [VA_W-1:0]   r_quo;
    logic [PB_W-1:0]   r_rem;
    logic [DC_W-1:0]   r_cnt;
    logic              r_wr;
    logic [CW-1:0]     r_idx;
    logic              r_cmp_v;
    logic [FW-1:0]     r_cmp_idx;
    logic [FW-1:0]     r_frame;
    logic [CW-1:0]     r_filled;
    logic [FW-1:0]     r_oldest;
    logic [KIND_W-1:0] r_kind;
    logic              r_ev_valid;
    logic [TAG_W-1:0]  r_ev_page;
    logic              r_wb;
    logic [PW-1:0]     r_prod;
    logic [PA_W-1:0]   r_pa;

    logic              r_out_valid;
    logic [OUT_W-1:0]  r_out_data;
    logic [KIND_W-1:0] r_out_kind;

    // frame memory: {page tag, write flag of the last access}
    logic [MW-1:0] r_mem [MAX_FRAMES];
    logic [MW-1:0] r_rd_data;
    logic [FW-1:0] rd_addr;
    logic          mem_we;

    logic [TAG_W-1:0] page;
    logic             in_acc;
    logic             out_free;
    logic             srch_hit;
    logic             srch_miss;
    logic             full;
    logic [FW-1:0]    victim;
    logic [FW-1:0]    next_oldest;
    logic [PB_W:0]    rem_sh;
    logic             rem_ge;

    assign page     = TAG_W'(r_quo);
    assign in_acc   = i_s_tvalid && o_s_tready;
    assign out_free = !r_out_valid || i_m_tready;
    assign srch_hit  = r_cmp_v && (r_rd_data[MW-1:1] == page);
    assign srch_miss = !r_cmp_v && (r_idx >= r_filled);
    assign full      = (r_filled >= limit);
    assign victim    = (CW'(r_oldest) < limit) ? r_oldest : '0;
    assign next_oldest = ((CW'(victim) + CW'(1)) >= limit) ? '0 : FW'(CW'(victim) + CW'(1));

    // one restoring division step
    assign rem_sh = {r_rem, r_quo[VA_W-1]};
    assign rem_ge = (rem_sh >= {1'b0, psz});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_s_tready = 1'b0;
        rd_addr    = r_idx[FW-1:0];
        mem_we     = 1'b0;
        case (r_state)
            ST_IDLE: begin
                // hold off beats while reset is applied
                o_s_tready = i_rst_n;
                if (i_s_tvalid) begin
                    n_state = ST_DIV;
                end
            end
            ST_DIV: begin
                if (r_cnt == DC_W'(VA_W - 1)) begin
                    n_state = ST_SRCH;
                end
            end
            ST_SRCH: begin
                if (srch_hit) begin
                    n_state = ST_MUL;
                end else if (srch_miss) begin
                    n_state = full ? ST_VRD : ST_MUL;
                end
            end
            ST_VRD: begin
                rd_addr = r_frame;
                n_state = ST_VCAP;
            end
            ST_VCAP: begin
                n_state = ST_MUL;
            end
            ST_MUL: begin
                n_state = ST_ADD;
            end
            ST_ADD: begin
                mem_we  = 1'b1;
                n_state = ST_OUT;
            end
            ST_OUT: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[r_frame] <= {page, r_wr};
        end
        r_rd_data <= r_mem[rd_addr];
    end

    // control state with reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_filled    <= '0;
            r_oldest    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_state == ST_SRCH && !srch_hit && srch_miss) begin
                if (full) begin
                    r_oldest <= next_oldest;
                end else begin
                    r_filled <= r_filled + CW'(1);
                end
            end
            if (r_state == ST_OUT && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    r_quo      <= i_s_tdata[VA_W-1:0];
                    r_wr       <= i_s_tuser[0];
                    r_rem      <= '0;
                    r_cnt      <= '0;
                    r_ev_valid <= 1'b0;
                    r_ev_page  <= '0;
                    r_wb       <= 1'b0;
                end
            end
            ST_DIV: begin
                r_rem   <= rem_ge ? PB_W'(rem_sh - {1'b0, psz}) : rem_sh[PB_W-1:0];
                r_quo   <= {r_quo[VA_W-2:0], rem_ge};
                r_cnt   <= r_cnt + DC_W'(1);
                r_idx   <= '0;
                r_cmp_v <= 1'b0;
            end
            ST_SRCH: begin
                // keep one read in flight, compare the previous one
                r_cmp_v   <= (r_idx < r_filled);
                r_cmp_idx <= r_idx[FW-1:0];
                if (r_idx < r_filled) begin
                    r_idx <= r_idx + CW'(1);
                end
                if (srch_hit) begin
                    r_frame <= r_cmp_idx;
                    r_kind  <= KIND_HIT;
                end else if (srch_miss) begin
                    r_kind <= {1'b0, r_wr};
                    if (full) begin
                        r_frame    <= victim;
                        r_ev_valid <= 1'b1;
                    end else begin
                        r_frame <= r_filled[FW-1:0];
                    end
                end
            end
            ST_VCAP: begin
                r_ev_page <= r_rd_data[MW-1:1];
                r_wb      <= r_rd_data[0];
            end
            ST_MUL: begin
                r_prod <= PW'(r_frame) * PW'(psz);
            end
            ST_ADD: begin
                r_pa <= PA_W'(r_prod + PW'(r_rem));
            end
            ST_OUT: begin
                if (out_free) begin
                    r_out_data <= {r_pa, r_wb, r_ev_page, r_ev_valid, page};
                    r_out_kind <= r_kind;
                end
            end
            default: begin
                r_cnt <= '0;
            end
        endcase
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;
    assign o_m_tuser  = r_out_kind;

`ifndef NO_ASSERTIONS
    a_filled_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_filled <= CW'(MAX_FRAMES))
        else $error("fill count beyond frame memory depth");

    a_filled_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && r_filled != $past(r_filled)) |->
            (r_filled == $past(r_filled) + CW'(1)))
        else $error("fill count moved by more than one");

    a_hit_no_evict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser == KIND_HIT) |-> !o_m_tdata[32])
        else $error("eviction reported on a hit");

    a_no_evict_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !o_m_tdata[32]) |-> (o_m_tdata[64:33] == '0 && !o_m_tdata[65]))
        else $error("victim page or write-back set without eviction");
`endif

endmodule
